FILE: sv/hkpt_pkg.sv
// types and constants for the held key press table
// used by hkpt_cell and held_key_press_table_core; depends on nothing
`default_nettype none

package hkpt_pkg;

  // widths of the result fields as seen at the ports
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;

  // action codes on the input word
  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_FIND_POS = 3'd2,
    ACT_FIND_ID  = 3'd3,
    ACT_IGNORE   = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_t;

  // status codes on the result word
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // sequencer states of the top level
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // one held press
  typedef struct packed {
    logic [7:0]  pos;
    logic [15:0] code;
    logic [7:0]  id;
    logic        ignore;
  } entry_t;

  // what a search looks for
  typedef struct packed {
    logic       by_id;
    logic [7:0] pos;
    logic [7:0] id;
  } query_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic   valid;
    logic   found;
    query_t query;
    entry_t hit;
  } scan_t;

  // table update broadcast to every cell
  typedef struct packed {
    logic append;
    logic remove;
    logic mark;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/hkpt_cell.sv
// one slot of the held key press table plus its stage of the search chain
// depends on hkpt_pkg
`default_nettype none

module hkpt_cell #(
  parameter int DEPTH      = 16,
  parameter int CELL_INDEX = 0,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [CNT_W-1:0]    count,
  input  wire hkpt_pkg::cmd_t      cmd,
  input  wire logic [CNT_W-1:0]    target,
  input  wire hkpt_pkg::entry_t    append_entry,
  input  wire hkpt_pkg::entry_t    upper_entry,
  output hkpt_pkg::entry_t         entry,
  input  wire hkpt_pkg::scan_t     scan_in,
  input  wire logic [IDX_W-1:0]    slot_in,
  output hkpt_pkg::scan_t          scan_out,
  output logic [IDX_W-1:0]         slot_out
);

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(CELL_INDEX);
  localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(CELL_INDEX);

  logic            occupied;
  logic            hit;
  hkpt_pkg::scan_t scan_next;
  logic [IDX_W-1:0] slot_next;

  // match against the word passing through
  assign occupied = (MY_IDX < count) && (CELL_INDEX < DEPTH);
  assign hit = scan_in.valid && !scan_in.found && occupied &&
               (scan_in.query.by_id ? (entry.id == scan_in.query.id)
                                    : (entry.pos == scan_in.query.pos));

  always_comb begin
    scan_next = scan_in;
    slot_next = slot_in;
    if (hit) begin
      scan_next.found = 1'b1;
      scan_next.hit   = entry;
      slot_next       = MY_SLOT;
    end
  end

  // search stage: token valid is control, the rest is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out.valid <= scan_next.valid;
    end
    scan_out.found <= scan_next.found;
    scan_out.query <= scan_next.query;
    scan_out.hit   <= scan_next.hit;
    slot_out       <= slot_next;
  end

  // table update: append, shift down on remove, or set the ignore flag
  always_ff @(posedge clk) begin
    if (cmd.append && (MY_IDX == target)) begin
      entry <= append_entry;
    end else if (cmd.remove && (MY_IDX >= target)) begin
      entry <= upper_entry;
    end else if (cmd.mark && (MY_IDX == target)) begin
      entry.ignore <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: sv/held_key_press_table_core.sv
// top level of the held key press table: sequencer, result register, cell chain
// depends on hkpt_pkg and hkpt_cell
//
//   channel | signals                                      | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid, in_stall, action, key_position,    | into block
//           | keycode, press_tag                           |
//   out     | out_valid, out_stall, status, slot,          | out of block
//           | found_position, found_keycode,               |
//           | found_press_tag, found_ignore, held_count    |
//
// one word at a time: the search word walks the cell chain one cell per cycle,
// then the finish state updates the table, loads the result and returns to idle.
// a new word is taken while the previous result still waits in the output register;
// the table update waits while that register is full and stalled.
// reset empties the table; entry contents are not cleared.
`default_nettype none

module held_key_press_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  key_position,
  input  wire logic [15:0] keycode,
  input  wire logic [7:0]  press_tag,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [3:0]       slot,
  output logic [7:0]       found_position,
  output logic [15:0]      found_keycode,
  output logic [7:0]       found_press_tag,
  output logic             found_ignore,
  output logic [4:0]       held_count
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  hkpt_pkg::state_t state, state_next;

  logic              accept;
  logic              commit;
  logic [CNT_W-1:0]  cnt, cnt_next;

  // request held during the search
  logic [2:0]        req_action;
  logic [7:0]        req_pos;
  logic [15:0]       req_code;
  logic [7:0]        req_id;

  // search outcome
  logic              res_found;
  logic [IDX_W-1:0]  res_slot;
  hkpt_pkg::entry_t  res_entry;

  // cell chain links
  hkpt_pkg::scan_t   scan_link  [0:TABLE_DEPTH];
  logic [IDX_W-1:0]  slot_link  [0:TABLE_DEPTH];
  hkpt_pkg::entry_t  entry_link [0:TABLE_DEPTH];

  hkpt_pkg::cmd_t    cmd;
  logic [CNT_W-1:0]  target;
  hkpt_pkg::entry_t  append_entry;

  // result decode
  hkpt_pkg::status_t r_status;
  logic [CNT_W-1:0]  r_slot;
  hkpt_pkg::entry_t  r_entry;
  logic              r_report;
  logic [CNT_W+hkpt_pkg::SLOT_W-1:0]  slot_wide;
  logic [CNT_W+hkpt_pkg::COUNT_W-1:0] count_wide;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hkpt_pkg::S_IDLE: begin
        if (in_valid) state_next = hkpt_pkg::S_SCAN;
      end
      hkpt_pkg::S_SCAN: begin
        if (scan_link[TABLE_DEPTH].valid) state_next = hkpt_pkg::S_FINISH;
      end
      hkpt_pkg::S_FINISH: begin
        if (!out_valid || !out_stall) state_next = hkpt_pkg::S_IDLE;
      end
      default: state_next = hkpt_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    commit   = 1'b0;
    unique case (state)
      hkpt_pkg::S_IDLE:   in_stall = 1'b0;
      hkpt_pkg::S_SCAN:   in_stall = 1'b1;
      hkpt_pkg::S_FINISH: commit   = !out_valid || !out_stall;
      default:            in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hkpt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_pos    <= key_position;
      req_code   <= keycode;
      req_id     <= press_tag;
    end
  end

  // launch the search word into the first cell
  always_comb begin
    scan_link[0].valid       = accept;
    scan_link[0].found       = 1'b0;
    scan_link[0].query.by_id = (action == hkpt_pkg::ACT_FIND_ID) ||
                               (action == hkpt_pkg::ACT_IGNORE);
    scan_link[0].query.pos   = key_position;
    scan_link[0].query.id    = press_tag;
    scan_link[0].hit         = '0;
    slot_link[0]             = '0;
  end

  // the last cell shifts in its own contents on remove
  assign entry_link[TABLE_DEPTH] = entry_link[TABLE_DEPTH-1];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    hkpt_cell #(
      .DEPTH      (TABLE_DEPTH),
      .CELL_INDEX (g),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .count        (cnt),
      .cmd          (cmd),
      .target       (target),
      .append_entry (append_entry),
      .upper_entry  (entry_link[g+1]),
      .entry        (entry_link[g]),
      .scan_in      (scan_link[g]),
      .slot_in      (slot_link[g]),
      .scan_out     (scan_link[g+1]),
      .slot_out     (slot_link[g+1])
    );
  end

  // catch the search word leaving the chain
  always_ff @(posedge clk) begin
    if (state == hkpt_pkg::S_SCAN && scan_link[TABLE_DEPTH].valid) begin
      res_found <= scan_link[TABLE_DEPTH].found;
      res_slot  <= slot_link[TABLE_DEPTH];
      res_entry <= scan_link[TABLE_DEPTH].hit;
    end
  end

  assign append_entry = '{pos: req_pos, code: req_code, id: req_id, ignore: 1'b0};

  // decide the table update and the result word
  always_comb begin
    cmd      = '0;
    target   = CNT_W'(res_slot);
    cnt_next = cnt;
    r_status = hkpt_pkg::ST_NOT_FOUND;
    r_slot   = CNT_W'(res_slot);
    r_entry  = res_entry;
    r_report = 1'b0;
    unique case (req_action)
      hkpt_pkg::ACT_ADD: begin
        if (res_found) begin
          r_status = hkpt_pkg::ST_DUPLICATE;
        end else if (cnt >= FULL_COUNT) begin
          r_status = hkpt_pkg::ST_FULL;
        end else begin
          cmd.append = commit;
          target     = cnt;
          cnt_next   = cnt + CNT_W'(1);
          r_status   = hkpt_pkg::ST_OK;
          r_slot     = cnt;
          r_entry    = append_entry;
          r_report   = 1'b1;
        end
      end
      hkpt_pkg::ACT_REMOVE: begin
        if (res_found) begin
          cmd.remove = commit;
          cnt_next   = cnt - CNT_W'(1);
          r_status   = hkpt_pkg::ST_OK;
        end
      end
      hkpt_pkg::ACT_FIND_POS, hkpt_pkg::ACT_FIND_ID: begin
        if (res_found) begin
          r_status = hkpt_pkg::ST_OK;
          r_report = 1'b1;
        end
      end
      hkpt_pkg::ACT_IGNORE: begin
        if (res_found) begin
          cmd.mark       = commit;
          r_status       = hkpt_pkg::ST_OK;
          r_entry.ignore = 1'b1;
          r_report       = 1'b1;
        end
      end
      hkpt_pkg::ACT_CLEAR: begin
        cnt_next = '0;
        r_status = hkpt_pkg::ST_OK;
      end
      default: r_status = hkpt_pkg::ST_NOT_FOUND;
    endcase
  end

  assign slot_wide  = (CNT_W + hkpt_pkg::SLOT_W)'(r_slot);
  assign count_wide = (CNT_W + hkpt_pkg::COUNT_W)'(cnt_next);

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (commit) begin
      cnt <= cnt_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status          <= r_status;
      held_count      <= count_wide[hkpt_pkg::COUNT_W-1:0];
      slot            <= r_report ? slot_wide[hkpt_pkg::SLOT_W-1:0] : '0;
      found_position  <= r_report ? r_entry.pos  : '0;
      found_keycode   <= r_report ? r_entry.code : '0;
      found_press_tag <= r_report ? r_entry.id   : '0;
      found_ignore    <= r_report ? r_entry.ignore : 1'b0;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FULL_COUNT)
    else $error("entry count beyond table depth");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    scan_link[TABLE_DEPTH].valid |-> state == hkpt_pkg::S_SCAN)
    else $error("search word left the chain outside a scan");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == hkpt_pkg::S_SCAN)
    else $error("accepted word did not start a scan");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == hkpt_pkg::S_FINISH)
    else $error("result word appeared without a finished scan");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for held_key_press_table_core: random words with gaps on both sides
// depends on hkpt_pkg and held_key_press_table_core; a scoreboard class predicts each result
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_WORDS = 800;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
  localparam int HOLD_AFTER = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  // action codes the block does not define
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  // one result word as seen on the output ports
  typedef struct {
    hkpt_pkg::status_t status;
    logic [3:0]  slot;
    logic [7:0]  position;
    logic [15:0] keycode;
    logic [7:0]  press_tag;
    logic        ignore;
    logic [4:0]  count;
  } press_result_t;

  // table predictor and expected result store
  class press_table_scoreboard;
    hkpt_pkg::entry_t held_press[TABLE_DEPTH];
    int            held_total;
    press_result_t pending_results[$];
    int unsigned   mismatches;

    function int locate_position(logic [7:0] pos);
      for (int i = 0; i < held_total; i++) begin
        if (held_press[i].pos == pos) return i;
      end
      return -1;
    endfunction

    function int locate_id(logic [7:0] id);
      for (int i = 0; i < held_total; i++) begin
        if (held_press[i].id == id) return i;
      end
      return -1;
    endfunction

    // apply one accepted word to the table and queue the result it should give
    function void note_word(logic [2:0] act, logic [7:0] pos, logic [15:0] code,
                            logic [7:0] id);
      press_result_t r;
      int hit;
      r.status = hkpt_pkg::ST_NOT_FOUND;
      r.slot = '0;
      r.position = '0;
      r.keycode = '0;
      r.press_tag = '0;
      r.ignore = 1'b0;
      hit = -1;
      case (act)
        hkpt_pkg::ACT_ADD: begin
          if (locate_position(pos) >= 0) begin
            r.status = hkpt_pkg::ST_DUPLICATE;
          end else if (held_total >= TABLE_DEPTH) begin
            r.status = hkpt_pkg::ST_FULL;
          end else begin
            held_press[held_total] = '{pos: pos, code: code, id: id, ignore: 1'b0};
            hit = held_total;
            held_total++;
          end
        end
        hkpt_pkg::ACT_REMOVE: begin
          hit = locate_position(pos);
          if (hit >= 0) begin
            // later entries close the gap, keeping their order
            for (int k = hit; k < held_total - 1; k++) held_press[k] = held_press[k + 1];
            held_total--;
            r.status = hkpt_pkg::ST_OK;
            hit = -1;
          end
        end
        hkpt_pkg::ACT_FIND_POS: hit = locate_position(pos);
        hkpt_pkg::ACT_FIND_ID:  hit = locate_id(id);
        hkpt_pkg::ACT_IGNORE: begin
          hit = locate_id(id);
          if (hit >= 0) held_press[hit].ignore = 1'b1;
        end
        hkpt_pkg::ACT_CLEAR: begin
          held_total = 0;
          r.status = hkpt_pkg::ST_OK;
        end
        default: ;
      endcase
      // report the entry touched, if any
      if (hit >= 0) begin
        r.status = hkpt_pkg::ST_OK;
        r.slot = hit[3:0];
        r.position = held_press[hit].pos;
        r.keycode = held_press[hit].code;
        r.press_tag = held_press[hit].id;
        r.ignore = held_press[hit].ignore;
      end
      r.count = held_total[4:0];
      pending_results.push_back(r);
    endfunction

    function string show(press_result_t r);
      return $sformatf("status %0d slot %0d pos %0d code %h id %0d ign %0d count %0d",
                       r.status, r.slot, r.position, r.keycode, r.press_tag, r.ignore,
                       r.count);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(press_result_t got);
      press_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("result with none expected: %s", show(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.slot !== want.slot ||
          got.position !== want.position || got.keycode !== want.keycode ||
          got.press_tag !== want.press_tag || got.ignore !== want.ignore ||
          got.count !== want.count) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch: expected %s", show(want));
          $display("          actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  action;
  logic [7:0]  key_position;
  logic [15:0] keycode;
  logic [7:0]  press_tag;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [3:0]  slot;
  logic [7:0]  found_position;
  logic [15:0] found_keycode;
  logic [7:0]  found_press_tag;
  logic        found_ignore;
  logic [4:0]  held_count;

  press_table_scoreboard sb = new;
  int unsigned words_in = 0;
  int unsigned words_out = 0;

  held_key_press_table_core #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key_position(key_position), .keycode(keycode),
    .press_tag(press_tag),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .slot(slot), .found_position(found_position),
    .found_keycode(found_keycode), .found_press_tag(found_press_tag),
    .found_ignore(found_ignore), .held_count(held_count)
  );

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 60);
    return $urandom_range(0, 2);
  endfunction

  // offer one word after a gap, hold it until taken; returns at the next falling edge
  task automatic send_word(logic [2:0] act, logic [7:0] pos, logic [15:0] code,
                           logic [7:0] id, int unsigned gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action = act;
    key_position = pos;
    keycode = code;
    press_tag = id;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(act, pos, code, id);
    words_in++;
    @(negedge clk);
  endtask

  // random word: positions and ids mostly from small pools so that hits are common
  task automatic send_random_word(bit fill_bias, bit calm);
    int unsigned r;
    logic [2:0] act;
    logic [7:0] pos;
    logic [7:0] id;
    r = $urandom_range(0, 99);
    if (fill_bias) begin
      act = r < 60 ? hkpt_pkg::ACT_ADD : r < 70 ? hkpt_pkg::ACT_REMOVE :
            r < 80 ? hkpt_pkg::ACT_FIND_POS : r < 90 ? hkpt_pkg::ACT_FIND_ID :
            r < 98 ? hkpt_pkg::ACT_IGNORE : ACT_SPARE_6;
    end else begin
      act = r < 36 ? hkpt_pkg::ACT_ADD : r < 54 ? hkpt_pkg::ACT_REMOVE :
            r < 68 ? hkpt_pkg::ACT_FIND_POS : r < 81 ? hkpt_pkg::ACT_FIND_ID :
            r < 94 ? hkpt_pkg::ACT_IGNORE : r < 96 ? hkpt_pkg::ACT_CLEAR :
            r < 98 ? ACT_SPARE_6 : ACT_SPARE_7;
    end
    pos = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, 23));
    id = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                     : 8'($urandom_range(0, 7));
    send_word(act, pos, 16'($urandom_range(0, 65535)), id, pick_gap(calm));
  endtask

  // reset, directed words, random words, drain
  initial begin : stimulus
    bit fill_bias;
    bit calm;
    rst = 1'b1;
    in_valid = 1'b0;
    action = hkpt_pkg::ACT_ADD;
    key_position = '0;
    keycode = '0;
    press_tag = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // empty table: every lookup misses
    send_word(hkpt_pkg::ACT_FIND_POS, 8'd0, 16'h0000, 8'd0, pick_gap(1'b0));
    send_word(hkpt_pkg::ACT_FIND_ID, 8'd0, 16'h0000, 8'd0, pick_gap(1'b0));
    send_word(hkpt_pkg::ACT_IGNORE, 8'd0, 16'h0000, 8'hff, pick_gap(1'b0));
    send_word(hkpt_pkg::ACT_REMOVE, 8'hff, 16'h0000, 8'd0, pick_gap(1'b0));
    // undefined actions change nothing
    send_word(ACT_SPARE_6, 8'hff, 16'hffff, 8'hff, pick_gap(1'b0));
    send_word(ACT_SPARE_7, 8'hff, 16'hffff, 8'hff, pick_gap(1'b0));
    // fill the table, field extremes first, press ids repeating
    send_word(hkpt_pkg::ACT_ADD, 8'd0, 16'h0000, 8'd0, pick_gap(1'b0));
    send_word(hkpt_pkg::ACT_ADD, 8'hff, 16'hffff, 8'hff, pick_gap(1'b0));
    for (int k = 1; k <= TABLE_DEPTH - 2; k++) begin
      send_word(hkpt_pkg::ACT_ADD, 8'(17 * k), 16'($urandom_range(0, 65535)),
                8'(k % 4), pick_gap(1'b0));
    end
    // full table: a duplicate position is reported ahead of the full table
    send_word(hkpt_pkg::ACT_ADD, 8'd0, 16'h1234, 8'd9, pick_gap(1'b0));
    send_word(hkpt_pkg::ACT_ADD, 8'd100, 16'h1234, 8'd9, pick_gap(1'b0));
    // repeated press id: the first match only
    send_word(hkpt_pkg::ACT_FIND_ID, 8'd0, 16'h0000, 8'd1, pick_gap(1'b0));
    send_word(hkpt_pkg::ACT_IGNORE, 8'd0, 16'h0000, 8'd1, pick_gap(1'b0));
    // remove the head, later entries move down
    send_word(hkpt_pkg::ACT_REMOVE, 8'd0, 16'h0000, 8'd0, pick_gap(1'b0));
    send_word(hkpt_pkg::ACT_FIND_POS, 8'hff, 16'h0000, 8'd0, pick_gap(1'b0));
    send_word(hkpt_pkg::ACT_FIND_ID, 8'd0, 16'h0000, 8'd1, pick_gap(1'b0));
    send_word(hkpt_pkg::ACT_CLEAR, 8'd0, 16'h0000, 8'd0, pick_gap(1'b0));

    // random part in stretches of fifty words, some of them add-heavy or gap-free
    fill_bias = 1'b0;
    calm = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) begin
        fill_bias = ($urandom_range(0, 2) == 0);
        calm = ($urandom_range(0, 3) == 0);
      end
      send_random_word(fill_bias, calm);
    end
    in_valid = 1'b0;

    // wait for every expected word, then a quiet tail
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver: random stalls, calm stretches, one long hold-off that backs up the input
  initial begin : receiver
    bit held_off;
    bit calm;
    held_off = 1'b0;
    out_stall = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!held_off && words_out >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        calm = ($urandom_range(0, 3) == 0);
        out_stall = 1'b0;
        repeat (calm ? $urandom_range(60, 160) : $urandom_range(1, 12)) @(negedge clk);
        if (!calm) begin
          out_stall = 1'b1;
          repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3))
            @(negedge clk);
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    press_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.status = hkpt_pkg::status_t'(status);
      got.slot = slot;
      got.position = found_position;
      got.keycode = found_keycode;
      got.press_tag = found_press_tag;
      got.ignore = found_ignore;
      got.count = held_count;
      sb.check_result(got);
      words_out++;
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin : watchdog
    int unsigned idle;
    int unsigned last_total;
    idle = 0;
    last_total = 0;
    forever begin
      @(negedge clk);
      if (words_in + words_out != last_total) begin
        last_total = words_in + words_out;
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

FILE: held_key_press_table_core.f
sv/hkpt_pkg.sv
sv/hkpt_cell.sv
sv/held_key_press_table_core.sv
tb/testbench.sv
